FILE: design/lac_pkg.sv
// shared constants, types and helpers for the look-at view matrix block
`timescale 1ns / 1ps
`default_nettype none
package lac_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int NV_W       = 52;                       // normaliser input width
  localparam int NM_W       = 30;                       // normalised magnitude width
  localparam int POS_W      = 6;                        // msb position of an NV_W word
  localparam int NORM_MSB   = 29;                       // target msb of the largest lane
  localparam int SQ_W       = 2 * NM_W;                 // one square
  localparam int SUMSQ_W    = SQ_W + 2;                 // sum of three squares
  localparam int SQRT_STEPS = SUMSQ_W / 2;              // one root bit per stage
  localparam int LEN_W      = SQRT_STEPS;               // root width
  localparam int DIV_STEPS  = FRAC_BITS + 1;            // quotient bits
  localparam int NUM_W      = NM_W + FRAC_BITS + 1;     // dividend width
  localparam int Q_W        = FRAC_BITS + 2;            // signed unit component
  localparam int NORM_LAT   = 6 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int U_W        = Q_W + 4;                  // recomputed up component
  localparam int SUM_W      = 58;                       // dot product accumulator
  localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(1) << FRAC_BITS;
  localparam logic [1:0] LAST_ROW_IDX = 2'd3;
  localparam logic [1:0] GAP_CYCLES   = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] e0;
    logic [WORD_W-1:0] e1;
    logic [WORD_W-1:0] e2;
    logic [WORD_W-1:0] e3;
  } row_t;

  typedef struct packed {
    row_t r0;
    row_t r1;
    row_t r2;
    logic degen;
  } mat_t;

  // clamp to a signed 32-bit word
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic [WORD_W-1:0] res;
    if (v[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){1'b0}} ||
        v[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){1'b1}})
      res = v[WORD_W-1:0];
    else if (v[SUM_W-1])
      res = {1'b1, {(WORD_W-1){1'b0}}};
    else
      res = {1'b0, {(WORD_W-1){1'b1}}};
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/lac_norm.sv
// pipelined three-lane vector normaliser: scale, sum of squares, root, divide
`timescale 1ns / 1ps
`default_nettype none
module lac_norm import lac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [NV_W-1:0] v0,
  input  logic signed [NV_W-1:0] v1,
  input  logic signed [NV_W-1:0] v2,
  output logic                   out_valid,
  output logic signed [Q_W-1:0]  n0,
  output logic signed [Q_W-1:0]  n1,
  output logic signed [Q_W-1:0]  n2,
  output logic                   zero
);

  logic signed [NV_W-1:0] vin [3];
  assign vin[0] = v0;
  assign vin[1] = v1;
  assign vin[2] = v2;

  // stage a: magnitudes
  logic            vld_a;
  logic [NV_W-1:0] mag_a [3];
  logic [2:0]      neg_a;
  // stage b: largest lane
  logic            vld_b;
  logic [NV_W-1:0] mag_b [3];
  logic [NV_W-1:0] mx_b;
  logic [2:0]      neg_b;
  logic            zero_b;
  // stage c: msb position
  logic             vld_c;
  logic [NV_W-1:0]  mag_c [3];
  logic [POS_W-1:0] pos_c;
  logic [2:0]       neg_c;
  logic             zero_c;
  // stage d: scaled lanes
  logic            vld_d;
  logic [NM_W-1:0] m_d [3];
  logic [2:0]      neg_d;
  logic            zero_d;
  // stage e: squares
  logic            vld_e;
  logic [NM_W-1:0] m_e [3];
  logic [SQ_W-1:0] sq_e [3];
  logic [2:0]      neg_e;
  logic            zero_e;
  // stage f: sum of squares
  logic               vld_f;
  logic [NM_W-1:0]    m_f [3];
  logic [SUMSQ_W-1:0] sum_f;
  logic [2:0]         neg_f;
  logic               zero_f;

  logic [NV_W-1:0]  mx_next;
  logic [POS_W-1:0] pos_next;
  logic [NV_W-1:0]  shl [3];

  always_comb begin
    mx_next = mag_a[0];
    if (mag_a[1] > mx_next) mx_next = mag_a[1];
    if (mag_a[2] > mx_next) mx_next = mag_a[2];
  end

  always_comb begin
    pos_next = '0;
    for (int b = 0; b < NV_W; b++) begin
      if (mx_b[b]) pos_next = POS_W'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_c >= POS_W'(NORM_MSB))
        shl[i] = mag_c[i] >> (pos_c - POS_W'(NORM_MSB));
      else
        shl[i] = mag_c[i] << (POS_W'(NORM_MSB) - pos_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      vld_e <= 1'b0;
      vld_f <= 1'b0;
    end else begin
      vld_a <= in_valid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
      vld_e <= vld_d;
      vld_f <= vld_e;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_a[i] <= vin[i][NV_W-1];
      mag_a[i] <= vin[i][NV_W-1] ? NV_W'(-vin[i]) : NV_W'(vin[i]);
      mag_b[i] <= mag_a[i];
      mag_c[i] <= mag_b[i];
      m_d[i]   <= shl[i][NM_W-1:0];
      m_e[i]   <= m_d[i];
      sq_e[i]  <= m_d[i] * m_d[i];
      m_f[i]   <= m_e[i];
    end
    mx_b   <= mx_next;
    neg_b  <= neg_a;
    zero_b <= (mx_next == '0);
    pos_c  <= pos_next;
    neg_c  <= neg_b;
    zero_c <= zero_b;
    neg_d  <= neg_c;
    zero_d <= zero_c;
    neg_e  <= neg_d;
    zero_e <= zero_d;
    sum_f  <= SUMSQ_W'(sq_e[0]) + SUMSQ_W'(sq_e[1]) + SUMSQ_W'(sq_e[2]);
    neg_f  <= neg_e;
    zero_f <= zero_e;
  end

  // square root, one result bit per stage
  logic               sq_vld  [SQRT_STEPS+1];
  logic [SUMSQ_W-1:0] sq_n    [SQRT_STEPS+1];
  logic [SUMSQ_W-1:0] sq_r    [SQRT_STEPS+1];
  logic [NM_W-1:0]    sq_m    [SQRT_STEPS+1][3];
  logic [2:0]         sq_neg  [SQRT_STEPS+1];
  logic               sq_zero [SQRT_STEPS+1];

  assign sq_vld[0]  = vld_f;
  assign sq_n[0]    = sum_f;
  assign sq_r[0]    = '0;
  assign sq_m[0]    = m_f;
  assign sq_neg[0]  = neg_f;
  assign sq_zero[0] = zero_f;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUMSQ_W-1:0] Bit = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * k);
    logic [SUMSQ_W-1:0] trial;
    assign trial = sq_r[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else sq_vld[k+1] <= sq_vld[k];
    end

    always_ff @(posedge clk) begin
      if (sq_n[k] >= trial) begin
        sq_n[k+1] <= sq_n[k] - trial;
        sq_r[k+1] <= (sq_r[k] >> 1) + Bit;
      end else begin
        sq_n[k+1] <= sq_n[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sq_m[k+1]    <= sq_m[k];
      sq_neg[k+1]  <= sq_neg[k];
      sq_zero[k+1] <= sq_zero[k];
    end
  end

  // rounded division by the length, one quotient bit per stage
  logic                 dv_vld  [DIV_STEPS+1];
  logic [NUM_W-1:0]     dv_rem  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_q    [DIV_STEPS+1][3];
  logic [LEN_W-1:0]     dv_len  [DIV_STEPS+1];
  logic [2:0]           dv_neg  [DIV_STEPS+1];
  logic                 dv_zero [DIV_STEPS+1];

  assign dv_vld[0]  = sq_vld[SQRT_STEPS];
  assign dv_len[0]  = sq_r[SQRT_STEPS][LEN_W-1:0];
  assign dv_neg[0]  = sq_neg[SQRT_STEPS];
  assign dv_zero[0] = sq_zero[SQRT_STEPS];
  for (genvar i = 0; i < 3; i++) begin : g_dinit
    assign dv_rem[0][i] = (NUM_W'(sq_m[SQRT_STEPS][i]) << FRAC_BITS) +
                          NUM_W'(dv_len[0] >> 1);
    assign dv_q[0][i]   = '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int Sh = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0] dvs;
    assign dvs = NUM_W'(dv_len[j]) << Sh;

    always_ff @(posedge clk) begin
      if (rst) dv_vld[j+1] <= 1'b0;
      else dv_vld[j+1] <= dv_vld[j];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= dvs) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - dvs;
          dv_q[j+1][i]   <= dv_q[j][i] | (DIV_STEPS'(1) << Sh);
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i];
        end
      end
      dv_len[j+1]  <= dv_len[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_zero[j+1] <= dv_zero[j];
    end
  end

  // sign restore
  logic signed [Q_W-1:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[DIV_STEPS])
        res[i] = '0;
      else if (dv_neg[DIV_STEPS][i])
        res[i] = -$signed(Q_W'(dv_q[DIV_STEPS][i]));
      else
        res[i] = $signed(Q_W'(dv_q[DIV_STEPS][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv_vld[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    n0   <= res[0];
    n1   <= res[1];
    n2   <= res[2];
    zero <= dv_zero[DIV_STEPS];
  end

endmodule
`default_nettype wire

FILE: design/lac_out.sv
// row sequencer: sends a finished matrix out as four words on consecutive cycles
`timescale 1ns / 1ps
`default_nettype none
module lac_out import lac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mat_t              mat,
  output logic              valid,
  output logic [1:0]        row_index,
  output logic [WORD_W-1:0] elem_0,
  output logic [WORD_W-1:0] elem_1,
  output logic [WORD_W-1:0] elem_2,
  output logic [WORD_W-1:0] elem_3,
  output logic              last_row,
  output logic              degenerate
);

  mat_t       hold;
  logic       active;
  logic [1:0] cnt;
  row_t       cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (in_valid) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 2'd1;
      if (cnt == LAST_ROW_IDX) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) hold <= mat;
  end

  always_comb begin
    case (cnt)
      2'd0:    cur = hold.r0;
      2'd1:    cur = hold.r1;
      2'd2:    cur = hold.r2;
      default: cur = '{e0: '0, e1: '0, e2: '0, e3: ONE_WORD};
    endcase
  end

  assign valid      = active;
  assign row_index  = cnt;
  assign elem_0     = cur.e0;
  assign elem_1     = cur.e1;
  assign elem_2     = cur.e2;
  assign elem_3     = cur.e3;
  assign last_row   = (cnt == LAST_ROW_IDX);
  assign degenerate = hold.degen;

endmodule
`default_nettype wire

FILE: design/look_at_view_matrix_top.sv
// top level of the look-at view matrix generator
`timescale 1ns / 1ps
`default_nettype none
// builds a 4x4 look-at view matrix from eye, target and up (signed q16.16).
// a word is taken at a clock edge where start is high and busy is low; busy then
// stays high while the gap counter runs down from GAP_CYCLES; the pipeline can
// take a new word before the rows of the last one are out. each word produces
// four result words, rows 0 to 3, each shown for exactly one cycle with valid
// high; the receiver cannot hold them off. rows 1 to 3 follow row 0 on
// consecutive cycles; last_row marks row 3. the path runs through the two
// normalisers in series (bit-per-stage square root and divide), and the gap
// counter spaces accepted words so that the four-row output sequencer ends one
// matrix before the next arrives. degenerate is high on all four rows when
// the forward or side vector had zero length. no clearing pass, no state
// between words.
module look_at_view_matrix_top import lac_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] eye_x,
  input  logic signed [WORD_W-1:0] eye_y,
  input  logic signed [WORD_W-1:0] eye_z,
  input  logic signed [WORD_W-1:0] target_x,
  input  logic signed [WORD_W-1:0] target_y,
  input  logic signed [WORD_W-1:0] target_z,
  input  logic signed [WORD_W-1:0] up_x,
  input  logic signed [WORD_W-1:0] up_y,
  input  logic signed [WORD_W-1:0] up_z,
  output logic                     valid,
  output logic [1:0]               row_index,
  output logic signed [WORD_W-1:0] elem_0,
  output logic signed [WORD_W-1:0] elem_1,
  output logic signed [WORD_W-1:0] elem_2,
  output logic signed [WORD_W-1:0] elem_3,
  output logic                     last_row,
  output logic                     degenerate
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  // accept spacing: busy holds start off while the gap counter runs
  logic [1:0] gap;
  logic       accept;
  assign busy   = (gap != 2'd0);
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) gap <= '0;
    else if (accept) gap <= GAP_CYCLES;
    else if (gap != 2'd0) gap <= gap - 2'd1;
  end

  // input register: eye, up and eye minus target
  logic                     vld_p;
  logic signed [WORD_W-1:0] eye_p [3];
  logic signed [WORD_W-1:0] up_p  [3];
  logic signed [WORD_W:0]   d_p   [3];

  always_ff @(posedge clk) begin
    if (rst) vld_p <= 1'b0;
    else vld_p <= accept;
  end

  always_ff @(posedge clk) begin
    eye_p[0] <= eye_x;
    eye_p[1] <= eye_y;
    eye_p[2] <= eye_z;
    up_p[0]  <= up_x;
    up_p[1]  <= up_y;
    up_p[2]  <= up_z;
    d_p[0]   <= (WORD_W+1)'(eye_x) - (WORD_W+1)'(target_x);
    d_p[1]   <= (WORD_W+1)'(eye_y) - (WORD_W+1)'(target_y);
    d_p[2]   <= (WORD_W+1)'(eye_z) - (WORD_W+1)'(target_z);
  end

  // forward axis
  logic                  f_vld;
  logic signed [Q_W-1:0] f_n [3];
  logic                  f_zero;

  lac_norm u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_p),
    .v0        (NV_W'(d_p[0])),
    .v1        (NV_W'(d_p[1])),
    .v2        (NV_W'(d_p[2])),
    .out_valid (f_vld),
    .n0        (f_n[0]),
    .n1        (f_n[1]),
    .n2        (f_n[2]),
    .zero      (f_zero)
  );

  // eye and up ride alongside the forward normaliser
  logic signed [WORD_W-1:0] dl_eye1 [NORM_LAT][3];
  logic signed [WORD_W-1:0] dl_up1  [NORM_LAT][3];

  always_ff @(posedge clk) begin
    dl_eye1[0] <= eye_p;
    dl_up1[0]  <= up_p;
    for (int k = 1; k < NORM_LAT; k++) begin
      dl_eye1[k] <= dl_eye1[k-1];
      dl_up1[k]  <= dl_up1[k-1];
    end
  end

  // cross product forward x up: products, then differences
  localparam int FU_W = Q_W + WORD_W;
  logic                     vld_x1, vld_x2;
  logic signed [FU_W-1:0]   fu [6];
  logic signed [Q_W-1:0]    f_x1 [3];
  logic signed [Q_W-1:0]    f_x2 [3];
  logic signed [WORD_W-1:0] eye_x1 [3];
  logic signed [WORD_W-1:0] eye_x2 [3];
  logic                     z_x1, z_x2;
  logic signed [FU_W:0]     c_x2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_x1 <= 1'b0;
      vld_x2 <= 1'b0;
    end else begin
      vld_x1 <= f_vld;
      vld_x2 <= vld_x1;
    end
  end

  always_ff @(posedge clk) begin
    fu[0]   <= f_n[1] * dl_up1[NORM_LAT-1][2];
    fu[1]   <= f_n[2] * dl_up1[NORM_LAT-1][1];
    fu[2]   <= f_n[2] * dl_up1[NORM_LAT-1][0];
    fu[3]   <= f_n[0] * dl_up1[NORM_LAT-1][2];
    fu[4]   <= f_n[0] * dl_up1[NORM_LAT-1][1];
    fu[5]   <= f_n[1] * dl_up1[NORM_LAT-1][0];
    f_x1    <= f_n;
    eye_x1  <= dl_eye1[NORM_LAT-1];
    z_x1    <= f_zero;
    c_x2[0] <= (FU_W+1)'(fu[0]) - (FU_W+1)'(fu[1]);
    c_x2[1] <= (FU_W+1)'(fu[2]) - (FU_W+1)'(fu[3]);
    c_x2[2] <= (FU_W+1)'(fu[4]) - (FU_W+1)'(fu[5]);
    f_x2    <= f_x1;
    eye_x2  <= eye_x1;
    z_x2    <= z_x1;
  end

  // side axis
  logic                  s_vld;
  logic signed [Q_W-1:0] s_n [3];
  logic                  s_zero;

  lac_norm u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_x2),
    .v0        (NV_W'(c_x2[0])),
    .v1        (NV_W'(c_x2[1])),
    .v2        (NV_W'(c_x2[2])),
    .out_valid (s_vld),
    .n0        (s_n[0]),
    .n1        (s_n[1]),
    .n2        (s_n[2]),
    .zero      (s_zero)
  );

  logic signed [Q_W-1:0]    dl_f2   [NORM_LAT][3];
  logic signed [WORD_W-1:0] dl_eye2 [NORM_LAT][3];
  logic                     dl_z2   [NORM_LAT];

  always_ff @(posedge clk) begin
    dl_f2[0]   <= f_x2;
    dl_eye2[0] <= eye_x2;
    dl_z2[0]   <= z_x2;
    for (int k = 1; k < NORM_LAT; k++) begin
      dl_f2[k]   <= dl_f2[k-1];
      dl_eye2[k] <= dl_eye2[k-1];
      dl_z2[k]   <= dl_z2[k-1];
    end
  end

  // u1: products for the true up axis and the side/forward translations
  localparam int SF_W = 2 * Q_W;
  localparam int BE_W = Q_W + WORD_W;
  localparam int UE_W = U_W + WORD_W;
  logic                     vld_u1, vld_u2, vld_u3, vld_u4;
  logic signed [SF_W-1:0]   sf [6];
  logic signed [BE_W-1:0]   se [3];
  logic signed [BE_W-1:0]   fe [3];
  logic signed [Q_W-1:0]    s_u1 [3];
  logic signed [Q_W-1:0]    f_u1 [3];
  logic signed [WORD_W-1:0] eye_u1 [3];
  logic                     dg_u1;

  logic signed [Q_W-1:0] f_in [3];
  assign f_in = dl_f2[NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_u1 <= 1'b0;
      vld_u2 <= 1'b0;
      vld_u3 <= 1'b0;
      vld_u4 <= 1'b0;
    end else begin
      vld_u1 <= s_vld;
      vld_u2 <= vld_u1;
      vld_u3 <= vld_u2;
      vld_u4 <= vld_u3;
    end
  end

  always_ff @(posedge clk) begin
    sf[0] <= s_n[1] * f_in[2];
    sf[1] <= s_n[2] * f_in[1];
    sf[2] <= s_n[2] * f_in[0];
    sf[3] <= s_n[0] * f_in[2];
    sf[4] <= s_n[0] * f_in[1];
    sf[5] <= s_n[1] * f_in[0];
    for (int i = 0; i < 3; i++) begin
      se[i] <= s_n[i] * dl_eye2[NORM_LAT-1][i];
      fe[i] <= f_in[i] * dl_eye2[NORM_LAT-1][i];
    end
    s_u1   <= s_n;
    f_u1   <= f_in;
    eye_u1 <= dl_eye2[NORM_LAT-1];
    dg_u1  <= dl_z2[NORM_LAT-1] | s_zero;
  end

  // u2: round the up axis, finish side and forward translations
  logic signed [SUM_W-1:0] u_raw [3];
  logic signed [SUM_W-1:0] t0_raw, t2_raw;

  always_comb begin
    u_raw[0] = (SUM_W'(sf[0]) - SUM_W'(sf[1]) + HALF) >>> FRAC_BITS;
    u_raw[1] = (SUM_W'(sf[2]) - SUM_W'(sf[3]) + HALF) >>> FRAC_BITS;
    u_raw[2] = (SUM_W'(sf[4]) - SUM_W'(sf[5]) + HALF) >>> FRAC_BITS;
    t0_raw = (HALF - SUM_W'(se[0]) - SUM_W'(se[1]) - SUM_W'(se[2])) >>> FRAC_BITS;
    t2_raw = (HALF - SUM_W'(fe[0]) - SUM_W'(fe[1]) - SUM_W'(fe[2])) >>> FRAC_BITS;
  end

  logic signed [U_W-1:0]    u_u2 [3];
  logic signed [Q_W-1:0]    s_u2 [3];
  logic signed [Q_W-1:0]    f_u2 [3];
  logic signed [WORD_W-1:0] eye_u2 [3];
  logic [WORD_W-1:0]        t0_u2, t2_u2;
  logic                     dg_u2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) u_u2[i] <= u_raw[i][U_W-1:0];
    s_u2   <= s_u1;
    f_u2   <= f_u1;
    eye_u2 <= eye_u1;
    t0_u2  <= sat_word(t0_raw);
    t2_u2  <= sat_word(t2_raw);
    dg_u2  <= dg_u1;
  end

  // u3: up axis against the eye
  logic signed [UE_W-1:0] ue [3];
  logic signed [U_W-1:0]  u_u3 [3];
  logic signed [Q_W-1:0]  s_u3 [3];
  logic signed [Q_W-1:0]  f_u3 [3];
  logic [WORD_W-1:0]      t0_u3, t2_u3;
  logic                   dg_u3;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) ue[i] <= u_u2[i] * eye_u2[i];
    u_u3  <= u_u2;
    s_u3  <= s_u2;
    f_u3  <= f_u2;
    t0_u3 <= t0_u2;
    t2_u3 <= t2_u2;
    dg_u3 <= dg_u2;
  end

  // u4: last translation, assemble the matrix
  logic signed [SUM_W-1:0] t1_raw;
  assign t1_raw = (HALF - SUM_W'(ue[0]) - SUM_W'(ue[1]) - SUM_W'(ue[2])) >>> FRAC_BITS;

  mat_t mat_u4;

  always_ff @(posedge clk) begin
    mat_u4.r0.e0 <= WORD_W'(s_u3[0]);
    mat_u4.r0.e1 <= WORD_W'(s_u3[1]);
    mat_u4.r0.e2 <= WORD_W'(s_u3[2]);
    mat_u4.r0.e3 <= t0_u3;
    mat_u4.r1.e0 <= WORD_W'(u_u3[0]);
    mat_u4.r1.e1 <= WORD_W'(u_u3[1]);
    mat_u4.r1.e2 <= WORD_W'(u_u3[2]);
    mat_u4.r1.e3 <= sat_word(t1_raw);
    mat_u4.r2.e0 <= WORD_W'(f_u3[0]);
    mat_u4.r2.e1 <= WORD_W'(f_u3[1]);
    mat_u4.r2.e2 <= WORD_W'(f_u3[2]);
    mat_u4.r2.e3 <= t2_u3;
    mat_u4.degen <= dg_u3;
  end

  // four result words per matrix
  logic [WORD_W-1:0] e0_w, e1_w, e2_w, e3_w;

  lac_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vld_u4),
    .mat        (mat_u4),
    .valid      (valid),
    .row_index  (row_index),
    .elem_0     (e0_w),
    .elem_1     (e1_w),
    .elem_2     (e2_w),
    .elem_3     (e3_w),
    .last_row   (last_row),
    .degenerate (degenerate)
  );

  assign elem_0 = $signed(e0_w);
  assign elem_1 = $signed(e1_w);
  assign elem_2 = $signed(e2_w);
  assign elem_3 = $signed(e3_w);

endmodule
`default_nettype wire
